[sv/slr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_pkg: shared definitions for the stereo linear resampler
// Fixed-point format, sample widths and the product width of the shared
// multiplier.
// ----------------------------------------------------------------------------
package slr_pkg;

   // Fraction bits of the read position and step (Q24 by default, 16..24).
   localparam int FRACTION_BITS = 24;

   localparam int SAMPLE_W = 16;
   // Position stays below 16.0 right after the last frame of a run.
   localparam int POS_W    = FRACTION_BITS + 6;
   localparam int STEP_W   = FRACTION_BITS + 5;
   // Unsigned fraction (zero-extended by one bit) times a signed sample.
   localparam int PROD_W   = FRACTION_BITS + SAMPLE_W + 1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]   product_type;
   typedef logic [FRACTION_BITS-1:0]   frac_type;

endpackage

[sv/slr_mul_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_mul_unit: shared fraction-by-difference multiplier
// One registered multiply of an unsigned fraction by a signed sample
// difference; the sequencer feeds it the left and then the right channel.
// ----------------------------------------------------------------------------
module slr_mul_unit
   import slr_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  frac_type    frac,
   input  sample_type  delta,
   output product_type product
);

   product_type product_ff;
   product_type product_in;

   always_comb begin
      product_in = $signed({1'b0, frac}) * delta;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

[sv/stereo_linear_resampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_linear_resampler: linear-interpolation stereo sample rate converter
// Takes one stereo request at a time and emits zero or more interpolated
// output frames, the last of each run flagged by rsp_last_of_run.
// ----------------------------------------------------------------------------
// Usage notes:
// A request (req_in_left, req_in_right) is taken when req_valid is high and
// req_stall is low. req_stall is high whenever the block is busy with a
// request, so only one request is in flight at a time.
// A request is accepted in the idle step, then the check step tests the read
// position and forms the saturated channel differences. Each output frame then
// passes the left multiply, right multiply and emit steps: the single shared
// multiplier handles the left channel, then the right channel, and the emit
// step loads the output register. A request that produces no frame returns
// to idle after the check step. A run is at most 64 frames, set by the
// clamped step size.
// Results sit in a single output register. While rsp_stall is high the
// register holds its frame and the sequencer waits in its emit step, so no
// frame is lost or repeated. The first frame of a run is presented once its
// request has passed the check, left multiply, right multiply and emit steps.
// Reset (synchronous, active high) clears the sample window and the read
// position, sets the step to 1.0 and selects linear interpolation.
// Configuration writes on csr_ are expected only while the block is idle.
// ----------------------------------------------------------------------------
module stereo_linear_resampler
   import slr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  sample_type        req_in_left,
   input  sample_type        req_in_right,
   // Response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sample_type        rsp_out_left,
   output sample_type        rsp_out_right,
   output logic              rsp_last_of_run,
   // Configuration write port
   input  logic              csr_wr_en,
   input  logic [0:0]        csr_index,
   input  logic [STEP_W-1:0] csr_wdata
);

   // Register indexes of the configuration port.
   localparam logic [0:0] REG_STEP_SIZE   = 1'b0;
   localparam logic [0:0] REG_INTERP_MODE = 1'b1;

   localparam logic [POS_W-1:0]  ONE_POS   = POS_W'(1) << FRACTION_BITS;
   localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1) << FRACTION_BITS;
   localparam logic [STEP_W-1:0] STEP_MIN  = STEP_W'(1) << (FRACTION_BITS - 6);
   localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(1) << (FRACTION_BITS + 4);
   localparam sample_type        SAMPLE_MAX = sample_type'(16'sh7fff);
   localparam sample_type        SAMPLE_MIN = sample_type'(16'sh8000);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_MUL_L = 5'b00100,
      ST_MUL_R = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // The step is limited so that a run never exceeds 64 frames.
   function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] s);
      logic [STEP_W-1:0] r;
      r = s;
      if (s < STEP_MIN) begin
         r = STEP_MIN;
      end else if (s > STEP_MAX) begin
         r = STEP_MAX;
      end
      return r;
   endfunction

   // Difference newer - older, saturated to the sample range.
   function automatic sample_type sat_delta(input sample_type newer,
                                            input sample_type older);
      logic signed [SAMPLE_W:0] d;
      sample_type               r;
      d = {newer[SAMPLE_W-1], newer} - {older[SAMPLE_W-1], older};
      if (d[SAMPLE_W] != d[SAMPLE_W-1]) begin
         r = d[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         r = d[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_size_ff, step_size_in;
   logic              interp_mode_ff, interp_mode_in;
   logic [STEP_W-1:0] step_used_ff, step_used_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   sample_type        older_left_ff, older_left_in;
   sample_type        older_right_ff, older_right_in;
   sample_type        newer_left_ff, newer_left_in;
   sample_type        newer_right_ff, newer_right_in;
   sample_type        pend_left_ff, pend_left_in;
   sample_type        pend_right_ff, pend_right_in;
   sample_type        delta_left_ff, delta_left_in;
   sample_type        delta_right_ff, delta_right_in;
   sample_type        left_res_ff, left_res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sample_type        rsp_left_ff, rsp_left_in;
   sample_type        rsp_right_ff, rsp_right_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              mul_enable;
   sample_type        mul_delta;
   product_type       product;
   sample_type        prod_step;
   logic [POS_W-1:0]  pos_sum;
   logic              pos_below_one;
   logic              frame_last;

   // The multiplier is busy in the two multiply steps and holds otherwise,
   // so the right-channel product survives a stalled emit step.
   assign mul_enable = (state_ff == ST_MUL_L) || (state_ff == ST_MUL_R);
   assign mul_delta  = (state_ff == ST_MUL_L) ? delta_left_ff : delta_right_ff;

   slr_mul_unit u_mul (
      .clock   (clock),
      .enable  (mul_enable),
      .frac    (pos_ff[FRACTION_BITS-1:0]),
      .delta   (mul_delta),
      .product (product)
   );

   // Arithmetic shift by the fraction width is a floor division; the
   // quotient always fits a sample because the fraction is below 1.0.
   assign prod_step     = product[FRACTION_BITS+SAMPLE_W-1:FRACTION_BITS];
   assign pos_below_one = (pos_ff[POS_W-1:FRACTION_BITS] == '0);
   assign pos_sum       = pos_ff + POS_W'(step_used_ff);
   assign frame_last    = (pos_sum[POS_W-1:FRACTION_BITS] != '0);

   always_comb begin
      state_in       = state_ff;
      step_size_in   = step_size_ff;
      interp_mode_in = interp_mode_ff;
      step_used_in   = step_used_ff;
      pos_in         = pos_ff;
      older_left_in  = older_left_ff;
      older_right_in = older_right_ff;
      newer_left_in  = newer_left_ff;
      newer_right_in = newer_right_ff;
      pend_left_in   = pend_left_ff;
      pend_right_in  = pend_right_ff;
      delta_left_in  = delta_left_ff;
      delta_right_in = delta_right_ff;
      left_res_in    = left_res_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_right_in   = rsp_right_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_STEP_SIZE:   step_size_in   = csr_wdata;
            REG_INTERP_MODE: interp_mode_in = csr_wdata[0];
            default:         step_size_in   = step_size_ff;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pend_left_in  = req_in_left;
               pend_right_in = req_in_right;
               step_used_in  = clamp_step(step_size_ff);
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            delta_left_in  = sat_delta(newer_left_ff, older_left_ff);
            delta_right_in = sat_delta(newer_right_ff, older_right_ff);
            if (pos_below_one) begin
               state_in = ST_MUL_L;
            end else begin
               // Downsampling gap: no frame, only the window moves on.
               pos_in         = pos_ff - ONE_POS;
               older_left_in  = newer_left_ff;
               older_right_in = newer_right_ff;
               newer_left_in  = pend_left_ff;
               newer_right_in = pend_right_ff;
               state_in       = ST_IDLE;
            end
         end
         ST_MUL_L: begin
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            left_res_in = interp_mode_ff ? older_left_ff + prod_step : older_left_ff;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = left_res_ff;
               rsp_right_in = interp_mode_ff ? older_right_ff + prod_step
                                             : older_right_ff;
               rsp_last_in  = frame_last;
               if (frame_last) begin
                  pos_in         = pos_sum - ONE_POS;
                  older_left_in  = newer_left_ff;
                  older_right_in = newer_right_ff;
                  newer_left_in  = pend_left_ff;
                  newer_right_in = pend_right_ff;
                  state_in       = ST_IDLE;
               end else begin
                  pos_in   = pos_sum;
                  state_in = ST_MUL_L;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_size_ff   <= STEP_ONE;
         interp_mode_ff <= 1'b1;
         pos_ff         <= '0;
         older_left_ff  <= '0;
         older_right_ff <= '0;
         newer_left_ff  <= '0;
         newer_right_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_size_ff   <= step_size_in;
         interp_mode_ff <= interp_mode_in;
         pos_ff         <= pos_in;
         older_left_ff  <= older_left_in;
         older_right_ff <= older_right_in;
         newer_left_ff  <= newer_left_in;
         newer_right_ff <= newer_right_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_used_ff   <= step_used_in;
      pend_left_ff   <= pend_left_in;
      pend_right_ff  <= pend_right_in;
      delta_left_ff  <= delta_left_in;
      delta_right_ff <= delta_right_in;
      left_res_ff    <= left_res_in;
      rsp_left_ff    <= rsp_left_in;
      rsp_right_ff   <= rsp_right_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_left    = rsp_left_ff;
   assign rsp_out_right   = rsp_right_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule
